FILE: rtl/core/assert_macros.svh
// assertion macros shared by the hash insert rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define HILP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define HILP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/hilp_pkg.sv
// types and constants of the linear probing hash insert block
package hilp_pkg;

  localparam int unsigned KEY_W          = 31;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned SLOT_W         = 10;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned SIZE_W         = 11;
  localparam int unsigned DEFAULT_SLOTS  = 1024;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(1021);

  // remainder unit retires this many dividend bits per cycle
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned DIV_STEPS      = (KEY_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int unsigned DIV_W          = DIV_STEPS * DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW    = 2'd0,
    ST_UPDATE = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic clear_wr;
    logic load_item;
    logic load_home;
    logic advance;
    logic commit_new;
    logic commit_upd;
    logic set_full;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic occ;
    logic match;
    logic wrap;
    logic clr_last;
    logic mod_done;
  } st_t;

endpackage

FILE: rtl/core/hilp_mod.sv
// multi-cycle remainder unit: key modulo table size
`include "assert_macros.svh"

module hilp_mod #(
  parameter int unsigned MAX_SLOTS = hilp_pkg::DEFAULT_SLOTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [hilp_pkg::KEY_W-1:0]          dividend_i,
  input  logic [$clog2(MAX_SLOTS):0]          divisor_i,
  output logic                                done_o,
  output logic [$clog2(MAX_SLOTS):0]          rem_o
);
  import hilp_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = IW + 1;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [CW-1:0]        div_q;
  logic [CW-1:0]        rem_q, rem_d;

  // restoring division, DIV_RADIX_BITS dividend bits per cycle
  always_comb begin
    rem_d = rem_q;
    for (int j = 0; j < DIV_RADIX_BITS; j++) begin
      rem_d = {rem_d[CW-2:0], dvd_q[DIV_W-1-j]};
      if (rem_d >= div_q) begin
        rem_d = rem_d - div_q;
      end
    end
    dvd_d = dvd_q << DIV_RADIX_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= DIV_W'(dividend_i);
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = busy_q && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign rem_o  = rem_q;

  `HILP_ASSERT_NEXT(a_rem_range, done_o, rem_q < div_q, "remainder not below divisor")

endmodule

FILE: rtl/core/hilp_dpath.sv
// datapath: table memories, probe index, counters and result registers
`include "assert_macros.svh"

module hilp_dpath #(
  parameter int unsigned MAX_SLOTS = hilp_pkg::DEFAULT_SLOTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hilp_pkg::SIZE_W-1:0]     cfg_data_i,
  input  logic [hilp_pkg::KEY_W-1:0]      key_i,
  input  logic [hilp_pkg::VALUE_W-1:0]    value_i,
  input  hilp_pkg::cmd_t                  cmd_i,
  output hilp_pkg::st_t                   st_o,
  output logic [hilp_pkg::STATUS_W-1:0]   status_o,
  output logic [hilp_pkg::SLOT_W-1:0]     slot_o,
  output logic [hilp_pkg::COUNT_W-1:0]    probe_count_o,
  output logic [hilp_pkg::COUNT_W-1:0]    entry_count_o
);
  import hilp_pkg::*;

  localparam int unsigned IW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = IW + 1;

  // each key word carries the occupied mark in its top bit
  logic [KEY_W:0]       key_mem [MAX_SLOTS];
  logic [VALUE_W-1:0]   val_mem [MAX_SLOTS];

  logic [SIZE_W-1:0]    tsz_q;
  logic [CW-1:0]        size;
  logic [KEY_W-1:0]     key_q;
  logic [VALUE_W-1:0]   value_q;
  logic [IW-1:0]        home_q, idx_q, nxt_idx;
  logic [CW-1:0]        idx_inc;
  logic [CW-1:0]        probes_q, count_q;
  logic [IW-1:0]        clr_idx_q;
  logic [KEY_W:0]       rd_data_q;
  logic [IW-1:0]        rd_addr, wr_addr;
  logic [KEY_W:0]       wr_data;
  logic                 wr_en;
  logic [CW-1:0]        rem;
  logic                 mod_done;
  status_e              res_status_q, out_status_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [COUNT_W-1:0]   out_probes_q, out_count_q;

  always_comb begin
    if (tsz_q == '0) begin
      size = CW'(1);
    end else if (32'(tsz_q) > 32'(MAX_SLOTS)) begin
      size = CW'(MAX_SLOTS);
    end else begin
      size = CW'(tsz_q);
    end
  end

  hilp_mod #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load_item),
    .dividend_i (key_i),
    .divisor_i  (size),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  // next probe slot wraps at the size in use
  assign idx_inc = {1'b0, idx_q} + CW'(1);
  assign nxt_idx = (idx_inc == size) ? '0 : idx_inc[IW-1:0];

  assign rd_addr = cmd_i.load_home ? rem[IW-1:0] : nxt_idx;
  assign wr_en   = cmd_i.clear_wr | cmd_i.commit_new | cmd_i.commit_upd;
  assign wr_addr = cmd_i.clear_wr ? clr_idx_q : idx_q;
  assign wr_data = cmd_i.clear_wr ? '0 : {1'b1, key_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_new || cmd_i.commit_upd) begin
      val_mem[idx_q] <= value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsz_q     <= TABLE_SIZE_RESET;
      clr_idx_q <= '0;
      count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        tsz_q <= cfg_data_i;
      end
      if (cmd_i.clear_wr) begin
        clr_idx_q <= clr_idx_q + IW'(1);
      end
      if (cmd_i.commit_new) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (cmd_i.load_home) begin
      home_q   <= rem[IW-1:0];
      idx_q    <= rem[IW-1:0];
      probes_q <= '0;
    end else begin
      if (cmd_i.advance) begin
        idx_q <= nxt_idx;
      end
      if (cmd_i.advance || cmd_i.commit_upd || cmd_i.set_full) begin
        probes_q <= probes_q + CW'(1);
      end
    end
    if (cmd_i.commit_new) begin
      res_status_q <= ST_NEW;
    end else if (cmd_i.commit_upd) begin
      res_status_q <= ST_UPDATE;
    end else if (cmd_i.set_full) begin
      res_status_q <= ST_FULL;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_slot_q   <= (res_status_q == ST_FULL) ? '0 : SLOT_W'(idx_q);
      out_probes_q <= COUNT_W'(probes_q);
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign st_o.occ      = rd_data_q[KEY_W];
  assign st_o.match    = rd_data_q[KEY_W-1:0] == key_q;
  assign st_o.wrap     = nxt_idx == home_q;
  assign st_o.clr_last = clr_idx_q == IW'(MAX_SLOTS - 1);
  assign st_o.mod_done = mod_done;

  assign status_o      = out_status_q;
  assign slot_o        = out_slot_q;
  assign probe_count_o = out_probes_q;
  assign entry_count_o = out_count_q;

  `HILP_ASSERT_NEXT(a_count_hold, !cmd_i.commit_new, $stable(count_q), "entry count moved without insert")
  `HILP_ASSERT(a_count_max, count_q <= CW'(MAX_SLOTS), "entry count above table capacity")

endmodule

FILE: rtl/core/hilp_ctrl.sv
// controller: sequences clear pass, modulo, probe walk and result transfer
`include "assert_macros.svh"

module hilp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  hilp_pkg::st_t   st_i,
  output hilp_pkg::cmd_t  cmd_o
);
  import hilp_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DIVIDE = 6'b000100,
    S_READ   = 6'b001000,
    S_PROBE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          state_d       = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (st_i.mod_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd.load_home = 1'b1;
        state_d       = S_PROBE;
      end
      S_PROBE: begin
        if (!st_i.occ) begin
          cmd.commit_new = 1'b1;
          state_d        = S_FINISH;
        end else if (st_i.match) begin
          cmd.commit_upd = 1'b1;
          state_d        = S_FINISH;
        end else if (st_i.wrap) begin
          // next slot would be the home slot
          cmd.set_full = 1'b1;
          state_d      = S_FINISH;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.load_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  `HILP_ASSERT(a_out_after_finish, $rose(out_valid_q) |-> $past(state_q == S_FINISH), "result without finish")

endmodule

FILE: rtl/core/hash_insert_linear_probing_top.sv
// Top level of an insert-only open-addressed hash table with linear probing. Each accepted
// key/value transfer computes home = key mod table_size in a remainder unit that retires four
// key bits per cycle, then walks slots home, home+1, ... through a key memory with registered
// read data, one slot per cycle, until it finds the key (update), a free slot (new entry) or
// wraps to home (table full). The length of an insert grows with the slots that the probe walk
// examines through the single read port of the key memory. Results wait in an output
// register, so the next insert is taken while the previous result is still stalled. After
// reset a clearing pass over all MAX_SLOTS slots empties the occupied marks; no insert is
// taken during it, but table_size writes are. A table_size of 0 acts as 1 and one above
// MAX_SLOTS acts as MAX_SLOTS; write it only while the block is idle.
module hash_insert_linear_probing_top #(
  parameter int unsigned MAX_SLOTS = hilp_pkg::DEFAULT_SLOTS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hilp_pkg::SIZE_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hilp_pkg::KEY_W-1:0]      key_i,
  input  logic [hilp_pkg::VALUE_W-1:0]    value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hilp_pkg::STATUS_W-1:0]   status_o,
  output logic [hilp_pkg::SLOT_W-1:0]     slot_o,
  output logic [hilp_pkg::COUNT_W-1:0]    probe_count_o,
  output logic [hilp_pkg::COUNT_W-1:0]    entry_count_o
);
  import hilp_pkg::*;

  cmd_t cmd;
  st_t  st;

  hilp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  hilp_dpath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .probe_count_o (probe_count_o),
    .entry_count_o (entry_count_o)
  );

endmodule
